/* src/qvr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared constants, widths, types and the arctangent table for the
// quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_COUNT    = 30;
   localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
   localparam int IDX_W         = 5;

   localparam int IN_W  = 32;
   localparam int ANG_W = 16;
   localparam int X_W   = 34;
   localparam int Z_W   = 33;

   localparam int CS_SHIFT = 30 - FRAC_BITS;
   localparam int CS_HALF  = (1 << CS_SHIFT) >> 1;
   localparam int CS_W     = FRAC_BITS + 3;
   localparam int U_W      = IN_W + CS_W - FRAC_BITS + 1;
   localparam int T_W      = U_W + IN_W + 3 - FRAC_BITS;
   localparam int A_W      = (T_W > IN_W) ? T_W : IN_W;
   localparam int P_W      = A_W + U_W;
   localparam int S_W      = P_W + 2;
   localparam int AL_W     = A_W / 2;
   localparam int BL_W     = U_W / 2;

   localparam logic signed [X_W-1:0] CORDIC_GAIN = X_W'(652032874);
   localparam int NUM_PROD = 12;

   typedef struct packed {
      logic signed [IN_W-1:0] vx;
      logic signed [IN_W-1:0] vy;
      logic signed [IN_W-1:0] vz;
      logic signed [IN_W-1:0] ax;
      logic signed [IN_W-1:0] ay;
      logic signed [IN_W-1:0] az;
      logic                   flip;
   } side_type;

   function automatic logic signed [Z_W-1:0] atan_lookup(input logic [IDX_W-1:0] idx);
      logic signed [Z_W-1:0] r;
      case (idx)
         5'd0:    r = Z_W'(536870912);
         5'd1:    r = Z_W'(316933406);
         5'd2:    r = Z_W'(167458907);
         5'd3:    r = Z_W'(85004756);
         5'd4:    r = Z_W'(42667331);
         5'd5:    r = Z_W'(21354465);
         5'd6:    r = Z_W'(10679838);
         5'd7:    r = Z_W'(5340245);
         5'd8:    r = Z_W'(2670163);
         5'd9:    r = Z_W'(1335087);
         5'd10:   r = Z_W'(667544);
         5'd11:   r = Z_W'(333772);
         5'd12:   r = Z_W'(166886);
         5'd13:   r = Z_W'(83443);
         5'd14:   r = Z_W'(41722);
         5'd15:   r = Z_W'(20861);
         5'd16:   r = Z_W'(10430);
         5'd17:   r = Z_W'(5215);
         5'd18:   r = Z_W'(2608);
         5'd19:   r = Z_W'(1304);
         5'd20:   r = Z_W'(652);
         5'd21:   r = Z_W'(326);
         5'd22:   r = Z_W'(163);
         5'd23:   r = Z_W'(81);
         5'd24:   r = Z_W'(41);
         5'd25:   r = Z_W'(20);
         5'd26:   r = Z_W'(10);
         5'd27:   r = Z_W'(5);
         5'd28:   r = Z_W'(3);
         5'd29:   r = Z_W'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

/* src/qvr_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_cordic_cell
// One rotation-mode CORDIC micro-rotation; carries the side payload along.
// ----------------------------------------------------------------------------
module qvr_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [qvr_pkg::IDX_W-1:0]     idx,
   input  logic                          valid_in,
   input  logic signed [qvr_pkg::X_W-1:0] x_in,
   input  logic signed [qvr_pkg::X_W-1:0] y_in,
   input  logic signed [qvr_pkg::Z_W-1:0] z_in,
   input  qvr_pkg::side_type             side_in,
   output logic                          valid_out,
   output logic signed [qvr_pkg::X_W-1:0] x_out,
   output logic signed [qvr_pkg::X_W-1:0] y_out,
   output logic signed [qvr_pkg::Z_W-1:0] z_out,
   output qvr_pkg::side_type             side_out
);
   import qvr_pkg::*;

   logic                  valid_ff;
   logic signed [X_W-1:0] x_ff, x_in_n, y_ff, y_in_n, dx, dy;
   logic signed [Z_W-1:0] z_ff, z_in_n, at;
   side_type              side_ff;

   always_comb begin
      dx = y_in >>> idx;
      dy = x_in >>> idx;
      at = atan_lookup(idx);
      if (!z_in[Z_W-1]) begin
         x_in_n = x_in - dx;
         y_in_n = y_in + dy;
         z_in_n = z_in - at;
      end else begin
         x_in_n = x_in + dx;
         y_in_n = y_in - dy;
         z_in_n = z_in + at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         x_ff    <= x_in_n;
         y_ff    <= y_in_n;
         z_ff    <= z_in_n;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

endmodule

/* src/qvr_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_mul
// Two-stage signed multiplier built from four narrow partial products.
// ----------------------------------------------------------------------------
module qvr_mul (
   input  logic                           clock,
   input  logic                           en,
   input  logic signed [qvr_pkg::A_W-1:0] a,
   input  logic signed [qvr_pkg::U_W-1:0] b,
   output logic signed [qvr_pkg::P_W-1:0] p
);
   import qvr_pkg::*;

   localparam int AH_W = A_W - AL_W;
   localparam int BH_W = U_W - BL_W;

   logic signed [AH_W-1:0]        a_hi;
   logic signed [AL_W:0]          a_lo;
   logic signed [BH_W-1:0]        b_hi;
   logic signed [BL_W:0]          b_lo;
   logic signed [AH_W+BH_W-1:0]   hh_ff;
   logic signed [AH_W+BL_W:0]     hl_ff;
   logic signed [AL_W+BH_W:0]     lh_ff;
   logic signed [AL_W+BL_W+1:0]   ll_ff;
   logic signed [P_W-1:0]         p_ff, p_in;

   assign a_hi = a[A_W-1:AL_W];
   assign a_lo = $signed({1'b0, a[AL_W-1:0]});
   assign b_hi = b[U_W-1:BL_W];
   assign b_lo = $signed({1'b0, b[BL_W-1:0]});

   assign p_in = (P_W'(hh_ff) <<< (AL_W + BL_W)) + (P_W'(hl_ff) <<< AL_W)
               + (P_W'(lh_ff) <<< BL_W) + P_W'(ll_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= a_hi * b_hi;
         hl_ff <= a_hi * b_lo;
         lh_ff <= a_lo * b_hi;
         ll_ff <= a_lo * b_lo;
         p_ff  <= p_in;
      end
   end

   assign p = p_ff;

endmodule

/* src/quaternion_vector_rotate.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a Q16.16 vector about an axis by a turn-fraction angle using
// quaternion products; sine and cosine of the half angle from a CORDIC.
//
// Usage:
//   req_* carries one word: vector, angle and axis; rsp_* returns the
//   rotated vector and an overflow flag, both with valid/ready handshakes.
//   Fully pipelined: one word accepted per cycle while the receiver is
//   not stalling. The path is an input register, a 16-cell CORDIC chain,
//   three two-stage multiplier banks, rounding and saturation registers.
//   While the receiver stalls a finished word, the whole pipeline holds
//   and req_ready drops; it resumes as soon as rsp_ready rises.
//   Reset clears all valid flags; no word is in flight afterward.
//   The axis is not normalized: a non-unit axis scales the result.
//   Outputs saturate to 32 bits and raise rsp_overflow.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_x,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_y,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_z,
   input  logic [qvr_pkg::ANG_W-1:0]        req_turn_angle,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_x,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_y,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_z,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [qvr_pkg::IN_W-1:0]  rsp_out_x,
   output logic signed [qvr_pkg::IN_W-1:0]  rsp_out_y,
   output logic signed [qvr_pkg::IN_W-1:0]  rsp_out_z,
   output logic                             rsp_overflow
);
   import qvr_pkg::*;

   localparam logic signed [S_W-1:0] SAT_MAX = S_W'(64'sd2147483647);
   localparam logic signed [S_W-1:0] SAT_MIN = S_W'(-64'sd2147483648);
   localparam logic signed [S_W-1:0] RND_HALF = S_W'(1) <<< (FRAC_BITS - 1);

   logic en;

   // chain of CORDIC cells
   logic                  c_v   [NUM_CELLS+1];
   logic signed [X_W-1:0] c_x   [NUM_CELLS+1];
   logic signed [X_W-1:0] c_y   [NUM_CELLS+1];
   logic signed [Z_W-1:0] c_z   [NUM_CELLS+1];
   side_type              c_s   [NUM_CELLS+1];

   logic                  in_v_ff;
   logic signed [Z_W-1:0] in_z_ff, in_z_in;
   side_type              in_s_ff, in_s_in;
   logic [IN_W-2:0]       half_ang;

   // stage A: cos/sin
   logic                   a_v_ff;
   logic signed [CS_W-1:0] a_c_ff, a_c_in, a_s_ff, a_s_in;
   side_type               a_side_ff;
   logic signed [X_W:0]    xf, yf;

   // bank 1
   logic                   b1_v_ff, b2_v_ff;
   logic signed [CS_W-1:0] b1_c_ff, b2_c_ff;
   side_type               b1_side_ff, b2_side_ff;
   logic signed [P_W-1:0]  m1_p [3];
   logic signed [A_W-1:0]  m1_a [3];

   // stage U
   logic                   u_v_ff;
   logic signed [CS_W-1:0] u_c_ff;
   logic signed [U_W-1:0]  u_ff [3];
   logic signed [U_W-1:0]  u_in [3];
   side_type               u_side_ff;

   // bank 2
   logic signed [A_W-1:0]  m2_a [NUM_PROD];
   logic signed [U_W-1:0]  m2_b [NUM_PROD];
   logic signed [P_W-1:0]  m2_p [NUM_PROD];
   logic                   d1_v_ff, d2_v_ff;
   logic signed [U_W-1:0]  d1_c_ff, d2_c_ff;
   logic signed [U_W-1:0]  d1_u_ff [3];
   logic signed [U_W-1:0]  d2_u_ff [3];
   logic signed [U_W-1:0]  u_cs;

   // stage T
   logic                   t_v_ff;
   logic signed [U_W-1:0]  t_c_ff;
   logic signed [U_W-1:0]  t_u_ff [3];
   logic signed [T_W-1:0]  t_ff [4];
   logic signed [T_W-1:0]  t_in [4];
   logic signed [S_W-1:0]  t_sum [4];

   // bank 3
   logic signed [A_W-1:0]  m3_a [NUM_PROD];
   logic signed [U_W-1:0]  m3_b [NUM_PROD];
   logic signed [P_W-1:0]  m3_p [NUM_PROD];
   logic                   n1_v_ff, n2_v_ff;

   // output
   logic signed [S_W-1:0]  o_sum [3];
   logic signed [S_W-1:0]  o_rnd [3];
   logic signed [IN_W-1:0] o_val [3];
   logic [2:0]             o_ovf;
   logic                   rsp_v_ff;
   logic signed [IN_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                   rsp_o_ff;

   assign en        = !rsp_v_ff || rsp_ready;
   assign req_ready = en;

   // angle reduction
   always_comb begin
      half_ang = {req_turn_angle, 15'd0};
      if (half_ang[IN_W-2]) begin
         in_z_in      = $signed({2'b11, half_ang});
         in_s_in.flip = 1'b1;
      end else begin
         in_z_in      = $signed({2'b00, half_ang});
         in_s_in.flip = 1'b0;
      end
      in_s_in.vx = req_vec_x;
      in_s_in.vy = req_vec_y;
      in_s_in.vz = req_vec_z;
      in_s_in.ax = req_axis_x;
      in_s_in.ay = req_axis_y;
      in_s_in.az = req_axis_z;
   end

   assign c_v[0] = in_v_ff;
   assign c_x[0] = CORDIC_GAIN;
   assign c_y[0] = '0;
   assign c_z[0] = in_z_ff;
   assign c_s[0] = in_s_ff;

   for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
      qvr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .idx       (IDX_W'(g)),
         .valid_in  (c_v[g]),
         .x_in      (c_x[g]),
         .y_in      (c_y[g]),
         .z_in      (c_z[g]),
         .side_in   (c_s[g]),
         .valid_out (c_v[g+1]),
         .x_out     (c_x[g+1]),
         .y_out     (c_y[g+1]),
         .z_out     (c_z[g+1]),
         .side_out  (c_s[g+1])
      );
   end

   always_comb begin
      if (c_s[NUM_CELLS].flip) begin
         xf = -(X_W+1)'(c_x[NUM_CELLS]);
         yf = -(X_W+1)'(c_y[NUM_CELLS]);
      end else begin
         xf = (X_W+1)'(c_x[NUM_CELLS]);
         yf = (X_W+1)'(c_y[NUM_CELLS]);
      end
      a_c_in = CS_W'((xf + (X_W+1)'(CS_HALF)) >>> CS_SHIFT);
      a_s_in = CS_W'((yf + (X_W+1)'(CS_HALF)) >>> CS_SHIFT);
   end

   assign m1_a[0] = A_W'(a_side_ff.ax);
   assign m1_a[1] = A_W'(a_side_ff.ay);
   assign m1_a[2] = A_W'(a_side_ff.az);

   for (genvar g = 0; g < 3; g++) begin : g_m1
      qvr_mul u_mul (
         .clock (clock),
         .en    (en),
         .a     (m1_a[g]),
         .b     (U_W'(a_s_ff)),
         .p     (m1_p[g])
      );
      assign u_in[g] = U_W'((S_W'(m1_p[g]) + RND_HALF) >>> FRAC_BITS);
   end

   // t = q * (0, v)
   assign u_cs = U_W'(u_c_ff);
   always_comb begin
      m2_a[0]  = A_W'(u_side_ff.vx); m2_b[0]  = u_ff[0];
      m2_a[1]  = A_W'(u_side_ff.vy); m2_b[1]  = u_ff[1];
      m2_a[2]  = A_W'(u_side_ff.vz); m2_b[2]  = u_ff[2];
      m2_a[3]  = A_W'(u_side_ff.vx); m2_b[3]  = u_cs;
      m2_a[4]  = A_W'(u_side_ff.vz); m2_b[4]  = u_ff[1];
      m2_a[5]  = A_W'(u_side_ff.vy); m2_b[5]  = u_ff[2];
      m2_a[6]  = A_W'(u_side_ff.vy); m2_b[6]  = u_cs;
      m2_a[7]  = A_W'(u_side_ff.vz); m2_b[7]  = u_ff[0];
      m2_a[8]  = A_W'(u_side_ff.vx); m2_b[8]  = u_ff[2];
      m2_a[9]  = A_W'(u_side_ff.vz); m2_b[9]  = u_cs;
      m2_a[10] = A_W'(u_side_ff.vy); m2_b[10] = u_ff[0];
      m2_a[11] = A_W'(u_side_ff.vx); m2_b[11] = u_ff[1];
   end

   for (genvar g = 0; g < NUM_PROD; g++) begin : g_m2
      qvr_mul u_mul (
         .clock (clock),
         .en    (en),
         .a     (m2_a[g]),
         .b     (m2_b[g]),
         .p     (m2_p[g])
      );
   end

   always_comb begin
      t_sum[0] = -S_W'(m2_p[0]) - S_W'(m2_p[1]) - S_W'(m2_p[2]);
      t_sum[1] =  S_W'(m2_p[3]) + S_W'(m2_p[4]) - S_W'(m2_p[5]);
      t_sum[2] =  S_W'(m2_p[6]) - S_W'(m2_p[7]) + S_W'(m2_p[8]);
      t_sum[3] =  S_W'(m2_p[9]) + S_W'(m2_p[10]) - S_W'(m2_p[11]);
      for (int k = 0; k < 4; k++) begin
         t_in[k] = T_W'((t_sum[k] + RND_HALF) >>> FRAC_BITS);
      end
   end

   // r = t * conj(q)
   always_comb begin
      m3_a[0]  = A_W'(t_ff[0]); m3_b[0]  = t_u_ff[0];
      m3_a[1]  = A_W'(t_ff[1]); m3_b[1]  = t_c_ff;
      m3_a[2]  = A_W'(t_ff[2]); m3_b[2]  = t_u_ff[2];
      m3_a[3]  = A_W'(t_ff[3]); m3_b[3]  = t_u_ff[1];
      m3_a[4]  = A_W'(t_ff[0]); m3_b[4]  = t_u_ff[1];
      m3_a[5]  = A_W'(t_ff[1]); m3_b[5]  = t_u_ff[2];
      m3_a[6]  = A_W'(t_ff[2]); m3_b[6]  = t_c_ff;
      m3_a[7]  = A_W'(t_ff[3]); m3_b[7]  = t_u_ff[0];
      m3_a[8]  = A_W'(t_ff[0]); m3_b[8]  = t_u_ff[2];
      m3_a[9]  = A_W'(t_ff[1]); m3_b[9]  = t_u_ff[1];
      m3_a[10] = A_W'(t_ff[2]); m3_b[10] = t_u_ff[0];
      m3_a[11] = A_W'(t_ff[3]); m3_b[11] = t_c_ff;
   end

   for (genvar g = 0; g < NUM_PROD; g++) begin : g_m3
      qvr_mul u_mul (
         .clock (clock),
         .en    (en),
         .a     (m3_a[g]),
         .b     (m3_b[g]),
         .p     (m3_p[g])
      );
   end

   always_comb begin
      o_sum[0] = -S_W'(m3_p[0]) + S_W'(m3_p[1]) - S_W'(m3_p[2]) + S_W'(m3_p[3]);
      o_sum[1] = -S_W'(m3_p[4]) + S_W'(m3_p[5]) + S_W'(m3_p[6]) - S_W'(m3_p[7]);
      o_sum[2] = -S_W'(m3_p[8]) - S_W'(m3_p[9]) + S_W'(m3_p[10]) + S_W'(m3_p[11]);
      for (int k = 0; k < 3; k++) begin
         o_rnd[k] = (o_sum[k] + RND_HALF) >>> FRAC_BITS;
         if (o_rnd[k] > SAT_MAX) begin
            o_val[k] = 32'sh7FFFFFFF;
            o_ovf[k] = 1'b1;
         end else if (o_rnd[k] < SAT_MIN) begin
            o_val[k] = 32'sh80000000;
            o_ovf[k] = 1'b1;
         end else begin
            o_val[k] = IN_W'(o_rnd[k]);
            o_ovf[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         a_v_ff   <= 1'b0;
         b1_v_ff  <= 1'b0;
         b2_v_ff  <= 1'b0;
         u_v_ff   <= 1'b0;
         d1_v_ff  <= 1'b0;
         d2_v_ff  <= 1'b0;
         t_v_ff   <= 1'b0;
         n1_v_ff  <= 1'b0;
         n2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else if (en) begin
         in_v_ff  <= req_valid;
         a_v_ff   <= c_v[NUM_CELLS];
         b1_v_ff  <= a_v_ff;
         b2_v_ff  <= b1_v_ff;
         u_v_ff   <= b2_v_ff;
         d1_v_ff  <= u_v_ff;
         d2_v_ff  <= d1_v_ff;
         t_v_ff   <= d2_v_ff;
         n1_v_ff  <= t_v_ff;
         n2_v_ff  <= n1_v_ff;
         rsp_v_ff <= n2_v_ff;
      end
      if (en) begin
         in_z_ff    <= in_z_in;
         in_s_ff    <= in_s_in;
         a_c_ff     <= a_c_in;
         a_s_ff     <= a_s_in;
         a_side_ff  <= c_s[NUM_CELLS];
         b1_c_ff    <= a_c_ff;
         b1_side_ff <= a_side_ff;
         b2_c_ff    <= b1_c_ff;
         b2_side_ff <= b1_side_ff;
         u_c_ff     <= b2_c_ff;
         u_side_ff  <= b2_side_ff;
         d1_c_ff    <= u_cs;
         d2_c_ff    <= d1_c_ff;
         t_c_ff     <= d2_c_ff;
         for (int k = 0; k < 3; k++) begin
            u_ff[k]    <= u_in[k];
            d1_u_ff[k] <= u_ff[k];
            d2_u_ff[k] <= d1_u_ff[k];
            t_u_ff[k]  <= d2_u_ff[k];
         end
         for (int k = 0; k < 4; k++) begin
            t_ff[k] <= t_in[k];
         end
         rsp_x_ff <= o_val[0];
         rsp_y_ff <= o_val[1];
         rsp_z_ff <= o_val[2];
         rsp_o_ff <= |o_ovf;
      end
   end

   assign rsp_valid    = rsp_v_ff;
   assign rsp_out_x    = rsp_x_ff;
   assign rsp_out_y    = rsp_y_ff;
   assign rsp_out_z    = rsp_z_ff;
   assign rsp_overflow = rsp_o_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         (rsp_out_x == 32'sh7FFFFFFF) || (rsp_out_x == 32'sh80000000) ||
         (rsp_out_y == 32'sh7FFFFFFF) || (rsp_out_y == 32'sh80000000) ||
         (rsp_out_z == 32'sh7FFFFFFF) || (rsp_out_z == 32'sh80000000))
      else $error("overflow flagged without a saturated component");

endmodule

/* dv/qvr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_checker
// Watches the request and response channels of the quaternion rotator,
// computes the expected rotated vector for every accepted request word and
// compares each accepted response word with the oldest expected one.
// ----------------------------------------------------------------------------
module qvr_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_x,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_y,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_vec_z,
   input  logic [qvr_pkg::ANG_W-1:0]        req_turn_angle,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_x,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_y,
   input  logic signed [qvr_pkg::IN_W-1:0]  req_axis_z,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  logic signed [qvr_pkg::IN_W-1:0]  rsp_out_x,
   input  logic signed [qvr_pkg::IN_W-1:0]  rsp_out_y,
   input  logic signed [qvr_pkg::IN_W-1:0]  rsp_out_z,
   input  logic                             rsp_overflow,
   output int                               fail_count,
   output int                               pending_count,
   output int                               rotated_count,
   output int                               saturated_count
);
   import qvr_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               ovf;
   } rotated_type;

   localparam logic signed [63:0] ARC_TABLE [30] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
      5, 3, 1};

   rotated_type rotated_q[$];

   function automatic logic signed [255:0] round_frac(input logic signed [255:0] v,
                                                      input int sh);
      if (sh == 0) return v;
      return (v + (256'sd1 <<< (sh - 1))) >>> sh;
   endfunction

   function automatic logic signed [31:0] clamp32(input logic signed [255:0] v,
                                                  inout logic ovf);
      if (v > 256'sh7FFFFFFF) begin
         ovf = 1'b1;
         return 32'h7FFFFFFF;
      end
      if (v < -256'sh80000000) begin
         ovf = 1'b1;
         return 32'h80000000;
      end
      return v[31:0];
   endfunction

   function automatic rotated_type rotate_vector(
         input logic signed [31:0] vx, vy, vz, input logic [15:0] ang,
         input logic signed [31:0] ax, ay, az);
      logic signed [63:0] cx, cy, cz, dx, dy;
      logic signed [255:0] s, sn, ux, uy, uz, tw, tx, ty, tz, wx, wy, wz, wz2;
      logic [63:0] h;
      logic flip;
      rotated_type r;
      h = 64'(ang) << 15;
      flip = h >= 64'h40000000;
      cz = flip ? $signed(h) - 64'sh80000000 : $signed(h);
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < CORDIC_STAGES && i < 30; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx -= dx; cy += dy; cz -= ARC_TABLE[i];
         end else begin
            cx += dx; cy -= dy; cz += ARC_TABLE[i];
         end
      end
      if (flip) begin
         cx = -cx;
         cy = -cy;
      end
      s  = round_frac(256'(cx), 30 - FRAC_BITS);
      sn = round_frac(256'(cy), 30 - FRAC_BITS);
      ux = round_frac(256'(ax) * sn, FRAC_BITS);
      uy = round_frac(256'(ay) * sn, FRAC_BITS);
      uz = round_frac(256'(az) * sn, FRAC_BITS);
      tw = round_frac(-ux * vx - uy * vy - uz * vz, FRAC_BITS);
      tx = round_frac(s * vx + uy * vz - uz * vy, FRAC_BITS);
      ty = round_frac(s * vy - ux * vz + uz * vx, FRAC_BITS);
      tz = round_frac(s * vz + ux * vy - uy * vx, FRAC_BITS);
      wx = round_frac(-tw * ux + tx * s - ty * uz + tz * uy, FRAC_BITS);
      wy = round_frac(-tw * uy + tx * uz + ty * s - tz * ux, FRAC_BITS);
      wz = round_frac(-tw * uz - tx * uy + ty * ux + tz * s, FRAC_BITS);
      r.ovf = 1'b0;
      r.x = clamp32(wx, r.ovf);
      r.y = clamp32(wy, r.ovf);
      r.z = clamp32(wz, r.ovf);
      return r;
   endfunction

   always @(posedge clock) begin
      rotated_type want;
      if (reset) begin
         fail_count = 0;
         rotated_count = 0;
         saturated_count = 0;
         pending_count = 0;
      end else begin
         if (req_valid && req_ready)
            rotated_q.push_back(rotate_vector(req_vec_x, req_vec_y, req_vec_z,
               req_turn_angle, req_axis_x, req_axis_y, req_axis_z));
         if (rsp_valid && rsp_ready) begin
            rotated_count++;
            if (rsp_overflow) saturated_count++;
            if (rotated_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected response word x=%0d y=%0d z=%0d",
                     rsp_out_x, rsp_out_y, rsp_out_z);
            end else begin
               want = rotated_q.pop_front();
               if (want.x !== rsp_out_x || want.y !== rsp_out_y ||
                   want.z !== rsp_out_z || want.ovf !== rsp_overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: exp x=%0d y=%0d z=%0d ovf=%0b got %0d %0d %0d %0b",
                        want.x, want.y, want.z, want.ovf,
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_overflow);
               end
            end
         end
         pending_count = rotated_q.size();
      end
   end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random rotation words into the quaternion rotator
// with random idling and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import qvr_pkg::*;

   localparam int N_RANDOM = 880;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = CORDIC_STAGES + 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic [15:0] req_turn_angle = '0;
   logic signed [31:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_overflow;
   int fail_count, pending_count, rotated_count, saturated_count;
   int cycle_count = 0;
   bit calm = 1'b0;
   bit hold_off = 1'b0;

   always #5 clock = ~clock;

   quaternion_vector_rotate u_top (.*);
   qvr_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // receiver: random stalls, none while calm, long stall while hold_off
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= !hold_off && (calm || $urandom_range(99) >= 34);
   end

   function automatic logic signed [31:0] rand_comp();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $signed(32'($urandom_range(131072))) - 65536;
         2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
         default: return $signed(32'($urandom_range(2097152))) - 1048576;
      endcase
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send(input logic signed [31:0] vx, vy, vz, input logic [15:0] ang,
                       input logic signed [31:0] ax, ay, az);
      while (!calm && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vec_x <= vx; req_vec_y <= vy; req_vec_z <= vz;
      req_turn_angle <= ang;
      req_axis_x <= ax; req_axis_y <= ay; req_axis_z <= az;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random();
      logic signed [31:0] ax, ay, az;
      if ($urandom_range(3) != 0) begin
         // unit axis along one direction, either sign
         ax = 0; ay = 0; az = 0;
         case ($urandom_range(2))
            0: ax = $urandom_range(1) ? 65536 : -65536;
            1: ay = $urandom_range(1) ? 65536 : -65536;
            default: az = $urandom_range(1) ? 65536 : -65536;
         endcase
      end else begin
         ax = rand_comp(); ay = rand_comp(); az = rand_comp();
      end
      send(rand_comp(), rand_comp(), rand_comp(), 16'($urandom()), ax, ay, az);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: quadrants, full-scale fields, non-unit axes
      send(65536, 0, 0, 16'h0000, 0, 0, 65536);
      send(65536, 0, 0, 16'h4000, 0, 0, 65536);
      send(65536, 0, 0, 16'h8000, 0, 0, 65536);
      send(65536, 0, 0, 16'hC000, 0, 0, 65536);
      send(0, 65536, 0, 16'hFFFF, 65536, 0, 0);
      send(0, 0, 65536, 16'h3FFF, 0, 65536, 0);
      send(65536, 65536, 65536, 16'h2000, 131072, 0, 0);
      send(65536, -65536, 0, 16'h6000, 32768, 32768, 32768);
      send(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'h0000, 0, 0, 0);
      send(32'sh80000000, 32'sh80000000, 32'sh80000000, 16'h8000, 0, 0, 65536);
      send(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 16'h2AAA,
           32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
      send(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 16'hA5A5,
           32'sh80000000, 32'sh80000000, 32'sh80000000);
      send(-1, -1, -1, 16'h5555, -1, -1, -1);
      send(1, 1, 1, 16'h0001, 1, 1, 1);
      send(-32'sd65536, 12345, -54321, 16'h7FFF, 0, -65536, 0);
      send(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 16'hAAAA,
           32'h55555555, 32'hAAAAAAAA, 32'h55555555);
      send(32'h55555555, 32'hAAAAAAAA, 32'h55555555, 16'h5555,
           32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
      // pause the sender until everything is back
      wait_drained();
      // hold off the receiver while words pile up
      hold_off = 1'b1;
      fork
         begin
            repeat (80) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            repeat (60) send_random();
            req_valid <= 1'b0;
         end
      join
      for (int n = 0; n < N_RANDOM; n++) begin
         calm = (n >= 300 && n < 450);
         send_random();
      end
      calm = 1'b0;
      wait_drained();
      $display("Rotated %0d words, %0d saturated, with random stalls on both sides.",
         rotated_count, saturated_count);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
